// ===== rtl/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg: shared types and rounding helpers for the quaternion rotate unit
// Holds component widths, the quaternion and vector structs, register
// indexes and the round/saturate functions of both Hamilton products.
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

  localparam int unsigned CompW  = 16;             // vector and quaternion parts
  localparam int unsigned MidW   = 18;             // first product, rounded
  localparam int unsigned Prod1W = 2 * CompW;      // q * v
  localparam int unsigned Sum1W  = Prod1W + 2;     // three terms
  localparam int unsigned Prod2W = MidW + CompW;   // p * q
  localparam int unsigned Sum2W  = Prod2W + 2;     // four terms
  localparam int unsigned FracW  = 14;             // Q2.14

  typedef enum logic [1:0] {
    REG_ROT_W = 2'd0,
    REG_ROT_X = 2'd1,
    REG_ROT_Y = 2'd2,
    REG_ROT_Z = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [CompW-1:0] w;
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [CompW-1:0] z;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] x;
  } vec_t;

  typedef struct packed {
    logic signed [MidW-1:0] pz;
    logic signed [MidW-1:0] py;
    logic signed [MidW-1:0] px;
    logic signed [MidW-1:0] pw;
  } mid_t;

  typedef struct packed {
    logic                    hit;
    logic signed [CompW-1:0] val;
  } sat_t;

  // Round half up (floor of s/2^14 + 1/2), then clamp to signed 18 bits.
  function automatic logic signed [MidW-1:0] round_sat_mid(logic signed [Sum1W-1:0] s);
    logic signed [Sum1W-1:0] r;
    logic signed [MidW-1:0]  res;
    r = (s + Sum1W'(1 << (FracW - 1))) >>> FracW;
    if (r > Sum1W'(131071)) begin
      res = 18'sd131071;
    end else if (r < -Sum1W'(131072)) begin
      res = -18'sd131072;
    end else begin
      res = r[MidW-1:0];
    end
    return res;
  endfunction

  // Round half up, then clamp to signed 16 bits and flag the clamp.
  function automatic sat_t round_sat_out(logic signed [Sum2W-1:0] s);
    logic signed [Sum2W-1:0] r;
    sat_t                    res;
    r = (s + Sum2W'(1 << (FracW - 1))) >>> FracW;
    if (r > Sum2W'(32767)) begin
      res.hit = 1'b1;
      res.val = 16'sd32767;
    end else if (r < -Sum2W'(32768)) begin
      res.hit = 1'b1;
      res.val = -16'sd32768;
    end else begin
      res.hit = 1'b0;
      res.val = r[CompW-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/qvr_left_prod.sv =====
// ----------------------------------------------------------------------------
// qvr_left_prod: first Hamilton product q * (0,v)
// Two register stages: twelve partial products, then signed sums rounded
// and clamped to 18 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_left_prod
  import qvr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire quat_t rot_i,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire vec_t  vec_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output mid_t       mid_o
);

  logic signed [CompW-1:0]  qa [4];
  logic signed [CompW-1:0]  va [3];
  logic signed [Prod1W-1:0] prod_d [4][3];
  logic signed [Prod1W-1:0] prod_q [4][3];
  logic                     vld0_q, vld1_q;
  logic                     en0, en1;
  mid_t                     mid_d, mid_q;

  assign en1        = !vld1_q || out_ready_i;
  assign en0        = !vld0_q || en1;
  assign in_ready_o = en0;

  assign qa[0] = rot_i.w;
  assign qa[1] = rot_i.x;
  assign qa[2] = rot_i.y;
  assign qa[3] = rot_i.z;
  assign va[0] = vec_i.x;
  assign va[1] = vec_i.y;
  assign va[2] = vec_i.z;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[k][j] = qa[k] * va[j];
      end
    end
  end

  // Product index: [quaternion part w,x,y,z][vector part x,y,z]
  always_comb begin
    mid_d.pw = round_sat_mid(-Sum1W'(prod_q[1][0]) - Sum1W'(prod_q[2][1])
                             - Sum1W'(prod_q[3][2]));
    mid_d.px = round_sat_mid(Sum1W'(prod_q[0][0]) + Sum1W'(prod_q[2][2])
                             - Sum1W'(prod_q[3][1]));
    mid_d.py = round_sat_mid(Sum1W'(prod_q[0][1]) - Sum1W'(prod_q[1][2])
                             + Sum1W'(prod_q[3][0]));
    mid_d.pz = round_sat_mid(Sum1W'(prod_q[0][2]) + Sum1W'(prod_q[1][1])
                             - Sum1W'(prod_q[2][0]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
    end else begin
      if (en0) vld0_q <= in_valid_i;
      if (en1) vld1_q <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) prod_q <= prod_d;
    if (en1 && vld0_q)     mid_q  <= mid_d;
  end

  assign out_valid_o = vld1_q;
  assign mid_o       = mid_q;

endmodule

`default_nettype wire

// ===== rtl/qvr_right_prod.sv =====
// ----------------------------------------------------------------------------
// qvr_right_prod: second Hamilton product p * conj(q), vector part only
// Two register stages: twelve partial products, then signed sums rounded,
// clamped to 16 bits and flagged on clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_right_prod
  import qvr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire quat_t rot_i,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire mid_t  mid_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output vec_t       res_o,
  output logic       clipped_o
);

  logic signed [Prod2W-1:0] term_d [3][4];
  logic signed [Prod2W-1:0] term_q [3][4];
  logic                     vld0_q, vld1_q;
  logic                     en0, en1;
  sat_t                     sx, sy, sz;
  vec_t                     res_q;
  logic                     clip_q;

  assign en1        = !vld1_q || out_ready_i;
  assign en0        = !vld0_q || en1;
  assign in_ready_o = en0;

  // Row per result component; terms ordered pw, px, py, pz.
  always_comb begin
    term_d[0][0] = mid_i.pw * rot_i.x;
    term_d[0][1] = mid_i.px * rot_i.w;
    term_d[0][2] = mid_i.py * rot_i.z;
    term_d[0][3] = mid_i.pz * rot_i.y;
    term_d[1][0] = mid_i.pw * rot_i.y;
    term_d[1][1] = mid_i.px * rot_i.z;
    term_d[1][2] = mid_i.py * rot_i.w;
    term_d[1][3] = mid_i.pz * rot_i.x;
    term_d[2][0] = mid_i.pw * rot_i.z;
    term_d[2][1] = mid_i.px * rot_i.y;
    term_d[2][2] = mid_i.py * rot_i.x;
    term_d[2][3] = mid_i.pz * rot_i.w;
  end

  always_comb begin
    sx = round_sat_out(-Sum2W'(term_q[0][0]) + Sum2W'(term_q[0][1])
                       - Sum2W'(term_q[0][2]) + Sum2W'(term_q[0][3]));
    sy = round_sat_out(-Sum2W'(term_q[1][0]) + Sum2W'(term_q[1][1])
                       + Sum2W'(term_q[1][2]) - Sum2W'(term_q[1][3]));
    sz = round_sat_out(-Sum2W'(term_q[2][0]) - Sum2W'(term_q[2][1])
                       + Sum2W'(term_q[2][2]) + Sum2W'(term_q[2][3]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
    end else begin
      if (en0) vld0_q <= in_valid_i;
      if (en1) vld1_q <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) term_q <= term_d;
    if (en1 && vld0_q) begin
      res_q.x <= sx.val;
      res_q.y <= sy.val;
      res_q.z <= sz.val;
      clip_q  <= sx.hit | sy.hit | sz.hit;
    end
  end

  assign out_valid_o = vld1_q;
  assign res_o       = res_q;
  assign clipped_o   = clip_q;

endmodule

`default_nettype wire

// ===== rtl/quaternion_vector_rotate_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit: rotate a stream of 3D vectors by a quaternion
// Computes q * (0,v) * conj(q) in fixed point and returns the vector part.
// ----------------------------------------------------------------------------
// The unit rotates each incoming vector (three signed 16-bit components) by
// the quaternion held in four Q2.14 registers (w, x, y, z; reset gives the
// identity w = 1.0). The quaternion is used as written, so a quaternion of
// length L also scales the vector by L*L. The first Hamilton product is
// rounded half up to 18 bits and clamped there silently; the second is
// rounded half up and clamped to signed 16 bits, and tuser reports whether
// any component clamped. The datapath is a five-register pipeline: products
// of q and v, sums of the first product, products with the conjugate, sums
// of the second product, and the output word register. One word enters per
// clock while the output side is not stalling; backpressure holds each full
// stage, empty stages ahead of a stall still fill, and nothing is dropped.
// Write the quaternion registers only while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_vector_rotate_unit
  import qvr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration write port
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [CompW-1:0]  cfg_wdata_i,
  // input vectors
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [47:0]       s_axis_tdata,   // vec_x, vec_y, vec_z
  // rotated vectors
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [47:0]            m_axis_tdata,   // out_x, out_y, out_z
  output logic                   m_axis_tuser    // clipped
);

  quat_t rot_q;
  vec_t  vec_in;
  mid_t  mid;
  logic  mid_valid, mid_ready;
  logic  res_valid, res_ready;
  vec_t  res;
  logic  res_clip;
  logic  out_vld_q;
  vec_t  out_q;
  logic  clip_q;

  // Quaternion registers; unknown codes cannot occur with a two-bit index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q.w <= 16'sd16384;
      rot_q.x <= '0;
      rot_q.y <= '0;
      rot_q.z <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_ROT_W: rot_q.w <= cfg_wdata_i;
        REG_ROT_X: rot_q.x <= cfg_wdata_i;
        REG_ROT_Y: rot_q.y <= cfg_wdata_i;
        REG_ROT_Z: rot_q.z <= cfg_wdata_i;
        default:   rot_q   <= rot_q;
      endcase
    end
  end

  assign vec_in.x = s_axis_tdata[15:0];
  assign vec_in.y = s_axis_tdata[31:16];
  assign vec_in.z = s_axis_tdata[47:32];

  qvr_left_prod u_left (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rot_i       (rot_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .vec_i       (vec_in),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .mid_o       (mid)
  );

  qvr_right_prod u_right (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rot_i       (rot_q),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .mid_i       (mid),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .res_o       (res),
    .clipped_o   (res_clip)
  );

  // Output word register: advance when empty or when the consumer takes it.
  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q  <= res;
      clip_q <= res_clip;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.z, out_q.y, out_q.x};
  assign m_axis_tuser  = clip_q;

endmodule

`default_nettype wire

// ===== tb/tb_quaternion_vector_rotate_unit.sv =====
// ----------------------------------------------------------------------------
// tb_quaternion_vector_rotate_unit: self-checking bench for the rotate unit
// Streams vectors through the unit under a series of quaternion settings and
// checks every rotated word against a bit-exact fixed-point predictor. Both
// stream sides idle at random; the quaternion is rewritten only when drained.
// ----------------------------------------------------------------------------
module tb_quaternion_vector_rotate_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import qvr_pkg::*;

  localparam int ClkHalf     = 2;
  localparam int IdlePct     = 28;
  localparam int SettleCyc   = 8;       // five-stage pipeline plus margin
  localparam int CycleLimit  = 200000;
  localparam int RandPhases  = 8;
  localparam int PhaseWords  = 80;

  // one rotated word as it leaves the unit
  typedef struct packed {
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] z;
    logic                    clipped;
  } rotated_t;

  // Predicts rotated words from accepted vectors and checks the unit's output.
  class rotate_scoreboard;
    logic signed [CompW-1:0] rot_reg [4];
    rotated_t                expected_rot [$];
    int                      err_count;

    function new();
      rot_reg[REG_ROT_W] = 16'sd16384;
      rot_reg[REG_ROT_X] = '0;
      rot_reg[REG_ROT_Y] = '0;
      rot_reg[REG_ROT_Z] = '0;
      err_count = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [CompW-1:0] val);
      rot_reg[idx] = val;
    endfunction

    function int pending();
      return expected_rot.size();
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
      err_count++;
    endtask

    // floor((s + 2^13) / 2^14): round half up
    function longint round_q14(longint s);
      return (s + 64'sd8192) >>> FracW;
    endfunction

    function longint clamp_to(longint v, longint lo, longint hi, inout bit hit);
      if (v < lo) begin
        hit = 1'b1;
        return lo;
      end
      if (v > hi) begin
        hit = 1'b1;
        return hi;
      end
      return v;
    endfunction

    // q * (0,v) * conj(q); the first product clamps silently at 18 bits
    function rotated_t predict_rotation(logic [47:0] d);
      longint   vx, vy, vz, w, x, y, z, pw, px, py, pz;
      bit       inner, clip;
      rotated_t r;
      vx = $signed(d[15:0]);
      vy = $signed(d[31:16]);
      vz = $signed(d[47:32]);
      w  = rot_reg[REG_ROT_W];
      x  = rot_reg[REG_ROT_X];
      y  = rot_reg[REG_ROT_Y];
      z  = rot_reg[REG_ROT_Z];
      inner = 1'b0;
      clip  = 1'b0;
      pw = clamp_to(round_q14(-x * vx - y * vy - z * vz), -131072, 131071, inner);
      px = clamp_to(round_q14( w * vx + y * vz - z * vy), -131072, 131071, inner);
      py = clamp_to(round_q14( w * vy - x * vz + z * vx), -131072, 131071, inner);
      pz = clamp_to(round_q14( w * vz + x * vy - y * vx), -131072, 131071, inner);
      r.x = 16'(clamp_to(round_q14(-pw * x + px * w - py * z + pz * y), -32768, 32767, clip));
      r.y = 16'(clamp_to(round_q14(-pw * y + px * z + py * w - pz * x), -32768, 32767, clip));
      r.z = 16'(clamp_to(round_q14(-pw * z - px * y + py * x + pz * w), -32768, 32767, clip));
      r.clipped = clip;
      return r;
    endfunction

    function void note_vector(logic [47:0] d);
      expected_rot.push_back(predict_rotation(d));
    endfunction

    task check_rotated(logic [47:0] d, logic clipped);
      rotated_t want;
      if (expected_rot.size() == 0) begin
        report_mismatch("unexpected word, x", $signed(d[15:0]), 0);
        return;
      end
      want = expected_rot.pop_front();
      if (d[15:0] !== want.x) report_mismatch("out_x", $signed(d[15:0]), want.x);
      if (d[31:16] !== want.y) report_mismatch("out_y", $signed(d[31:16]), want.y);
      if (d[47:32] !== want.z) report_mismatch("out_z", $signed(d[47:32]), want.z);
      if (clipped !== want.clipped) report_mismatch("clipped", clipped, want.clipped);
    endtask
  endclass

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [1:0]       cfg_idx_i     = '0;
  logic [CompW-1:0] cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [47:0]      s_axis_tdata  = '0;   // vec_x, vec_y, vec_z
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [47:0]      m_axis_tdata;         // out_x, out_y, out_z
  logic             m_axis_tuser;         // clipped

  rotate_scoreboard sb;
  bit               tx_quiet = 1'b0;      // sender never idles while set
  bit               rx_quiet = 1'b0;      // receiver never stalls while set
  int unsigned      cycle_count = 0;

  quaternion_vector_rotate_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Stall the output side about IdlePct of the time unless told otherwise.
  always @(posedge clk_i) begin
    m_axis_tready <= rx_quiet || ($urandom_range(0, 99) >= IdlePct);
  end

  // Observe all three ports at the edge; every input here is driven by
  // nonblocking assignment, so these are the values the unit saw.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(reg_idx_e'(cfg_idx_i), cfg_wdata_i);
      if (s_axis_tvalid && s_axis_tready) sb.note_vector(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_rotated(m_axis_tdata, m_axis_tuser);
    end
  end

  // Abort a hung run.
  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one word; idle at random first, then hold it until accepted.
  task automatic send_word(logic [47:0] d);
    while (!tx_quiet && ($urandom_range(0, 99) < IdlePct)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_vec(int vx, int vy, int vz);
    send_word({16'(vz), 16'(vy), 16'(vx)});
  endtask

  // Drop valid and hold until every predicted word has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // Drain the pipeline, then write all four quaternion registers.
  task automatic load_quat(int w, int x, int y, int z);
    reg_idx_e idx [4];
    int       val [4];
    idx = '{REG_ROT_W, REG_ROT_X, REG_ROT_Y, REG_ROT_Z};
    val = '{w, x, y, z};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx[i];
      cfg_wdata_i <= 16'(val[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Favor the extremes and small values; otherwise any 16-bit pattern.
  function automatic logic [15:0] rand_comp();
    logic [15:0] r;
    r = 16'($urandom());
    case ($urandom_range(0, 9))
      0: r = 16'h8000;
      1: r = 16'h7fff;
      2, 3: r = 16'($urandom_range(0, 64) - 32);
      default: ;
    endcase
    return r;
  endfunction

  // Quaternion part: any pattern, roughly unit length, or an extreme.
  function automatic int rand_quat_part(int mode);
    int r;
    case (mode)
      0: r = $signed(16'($urandom()));
      1: r = $urandom_range(0, 23170) - 11585;
      default: r = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
    endcase
    return r;
  endfunction

  initial begin : stimulus
    int mode;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity after reset: extremes of every component
    send_vec(0, 0, 0);
    send_vec(32767, 32767, 32767);
    send_vec(-32768, -32768, -32768);
    send_vec(1, -1, 32767);
    send_vec(-32768, 32767, 0);

    // w = 0.5: products land exactly on the rounding halfway point
    load_quat(8192, 0, 0, 0);
    send_vec(1, -1, 3);
    send_vec(-3, 5, -32768);

    // 90 degrees about z
    load_quat(11585, 0, 0, 11585);
    send_vec(1000, 0, 0);
    send_vec(0, -1000, 12345);
    send_vec(32767, -32768, 1);

    // largest quaternions: both products saturate
    load_quat(32767, 32767, 32767, 32767);
    send_vec(32767, 32767, 32767);
    send_vec(-32768, 1, -1);
    load_quat(-32768, -32768, -32768, -32768);
    send_vec(-32768, -32768, -32768);
    send_vec(32767, -32768, 32767);

    // 180 degrees about x, then a mixed-sign quaternion
    load_quat(0, 16384, 0, 0);
    send_vec(100, 200, 300);
    load_quat(-32768, 32767, 0, -1);
    send_vec(-1, 2, -32768);

    // random phases, each under a fresh quaternion
    for (int p = 0; p < RandPhases; p++) begin
      mode = p % 3;
      load_quat(rand_quat_part(mode), rand_quat_part(mode),
                rand_quat_part(mode), rand_quat_part(mode));
      tx_quiet = (p == 3);
      rx_quiet = (p == 3);
      for (int n = 0; n < PhaseWords; n++) begin
        // pause the sender once mid-phase until the pipeline empties
        if (p == 5 && n == PhaseWords / 2) drain();
        send_word({rand_comp(), rand_comp(), rand_comp()});
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    drain();
    if (sb.pending() != 0) sb.report_mismatch("words never returned", sb.pending(), 0);
    if (sb.err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== quaternion_vector_rotate_unit.f =====
rtl/qvr_pkg.sv
rtl/qvr_left_prod.sv
rtl/qvr_right_prod.sv
rtl/quaternion_vector_rotate_unit.sv
tb/tb_quaternion_vector_rotate_unit.sv
